>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/xalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xalu_pkg
// Operation codes and request, result and divider control types of the ALU.
// ----------------------------------------------------------------------------
package xalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_IMUL = 4'd3,
		OP_DIV  = 4'd4,
		OP_IDIV = 4'd5,
		OP_CMP  = 4'd6,
		OP_AND  = 4'd7,
		OP_OR   = 4'd8,
		OP_XOR  = 4'd9,
		OP_NOT  = 4'd10,
		OP_NOP  = 4'd15
	} alu_op_t;

	localparam logic [3:0] MODE_MAX = 4'd10;
	localparam int DIV_STEPS = 16;

	typedef struct packed {
		alu_op_t     op;
		logic        is_byte;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] al;
		logic [15:0] ah;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] dres;
		logic        wd;
		logic [15:0] lo;
		logic [15:0] hi;
		logic        wl;
		logic        wh;
		logic        cf;
		logic        of;
		logic        sf;
		logic        zf;
		logic        fv;
		logic        de;
	} alu_res_t;

	typedef struct packed {
		logic        is_div;
		logic        is_signed;
		logic        is_byte;
		logic        neg_d;
		logic        neg_v;
		logic        bad;
		logic [15:0] dvsr;
	} div_ctl_t;

endpackage

>>> rtl/x86_style_alu_8_16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_style_alu_8_16
// Byte or word integer ALU with add, sub, cmp, logic, not, mul and div.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle for every operation while out_stall is low.
// The sixteen-stage pipelined restoring divider sets the latency.
// Reset clears all valid bits and queue pointers; the block is ready at once.
module x86_style_alu_8_16 import xalu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic        is_byte,
	input  logic [15:0] dest_value,
	input  logic [15:0] src_value,
	input  logic [15:0] acc_low_in,
	input  logic [15:0] acc_high_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] dest_result,
	output logic        write_dest,
	output logic [15:0] acc_low_out,
	output logic [15:0] acc_high_out,
	output logic        write_acc_low,
	output logic        write_acc_high,
	output logic        carry_flag,
	output logic        overflow_flag,
	output logic        sign_flag,
	output logic        zero_flag,
	output logic        flags_valid,
	output logic        divide_error
);

	logic     q_full;
	logic     req_valid;
	alu_req_t req;
	logic     pop;
	logic     head_valid;
	alu_req_t head;

	xalu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.is_byte     (is_byte),
		.dest_value  (dest_value),
		.src_value   (src_value),
		.acc_low_in  (acc_low_in),
		.acc_high_in (acc_high_in),
		.q_full      (q_full),
		.req_valid   (req_valid),
		.req         (req)
	);

	xalu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_valid),
		.push_req   (req),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	xalu_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.dest_result    (dest_result),
		.write_dest     (write_dest),
		.acc_low_out    (acc_low_out),
		.acc_high_out   (acc_high_out),
		.write_acc_low  (write_acc_low),
		.write_acc_high (write_acc_high),
		.carry_flag     (carry_flag),
		.overflow_flag  (overflow_flag),
		.sign_flag      (sign_flag),
		.zero_flag      (zero_flag),
		.flags_valid    (flags_valid),
		.divide_error   (divide_error)
	);

endmodule

>>> rtl/xalu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xalu_front
// Accepts requests, decodes the mode and masks the operands to the width.
// ----------------------------------------------------------------------------
module xalu_front import xalu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic        is_byte,
	input  logic [15:0] dest_value,
	input  logic [15:0] src_value,
	input  logic [15:0] acc_low_in,
	input  logic [15:0] acc_high_in,
	input  logic        q_full,
	output logic        req_valid,
	output alu_req_t    req
);

	logic     req_valid_q;
	alu_req_t req_q;
	alu_req_t dec;

	always_comb begin
		dec.op      = (mode > MODE_MAX) ? OP_NOP : alu_op_t'(mode);
		dec.is_byte = is_byte;
		dec.a       = is_byte ? {8'h00, dest_value[7:0]} : dest_value;
		dec.b       = is_byte ? {8'h00, src_value[7:0]} : src_value;
		dec.al      = acc_low_in;
		dec.ah      = acc_high_in;
	end

	assign in_stall  = req_valid_q & q_full;
	assign req_valid = req_valid_q;
	assign req       = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
		end else if (!in_stall) begin
			req_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q <= dec;
		end
	end

endmodule

>>> rtl/xalu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xalu_queue
// Two-entry request queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module xalu_queue import xalu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  alu_req_t push_req,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output alu_req_t head
);

	alu_req_t    mem_q [0:1];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	`ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "Queue count out of range.")
	`ASSERT_NEXT(a_push_counts, do_push && !do_pop, cnt_q == $past(cnt_q) + 2'd1,
		"Queue count did not grow on a push.")

endmodule

>>> rtl/xalu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xalu_back
// Executes requests: arithmetic, logic and multiply in the first stage, then
// a sixteen-stage restoring divider, then the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module xalu_back import xalu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  alu_req_t    head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] dest_result,
	output logic        write_dest,
	output logic [15:0] acc_low_out,
	output logic [15:0] acc_high_out,
	output logic        write_acc_low,
	output logic        write_acc_high,
	output logic        carry_flag,
	output logic        overflow_flag,
	output logic        sign_flag,
	output logic        zero_flag,
	output logic        flags_valid,
	output logic        divide_error
);

	logic        en;
	logic        out_valid_q;
	alu_res_t    out_q;

	logic        vld_s [0:DIV_STEPS];
	alu_res_t    res_s [0:DIV_STEPS];
	div_ctl_t    ctl_s [0:DIV_STEPS];
	logic [15:0] rem_s [0:DIV_STEPS];
	logic [15:0] quo_s [0:DIV_STEPS];

	alu_res_t    ex;
	div_ctl_t    ex_ctl;
	logic [15:0] m;
	logic [15:0] top;
	logic [16:0] sum;
	logic [16:0] diff;
	logic [15:0] fres;
	logic        sx;
	logic [16:0] ma;
	logic [16:0] mb;
	logic [33:0] prod;
	logic [31:0] p;
	logic        mul_big;
	logic [31:0] dvd;
	logic [31:0] mag_d;
	logic [15:0] vs;
	logic [15:0] mag_v;

	assign en  = ~out_valid_q | ~out_stall;
	assign pop = en & head_valid;

	always_comb begin
		m    = head.is_byte ? 16'h00FF : 16'hFFFF;
		top  = head.is_byte ? 16'h0080 : 16'h8000;
		sum  = {1'b0, head.a} + {1'b0, head.b};
		diff = {1'b0, head.a} - {1'b0, head.b};
		sx   = head.op == OP_IMUL;
		ma   = head.is_byte ? {{9{sx & head.al[7]}}, head.al[7:0]}
			: {sx & head.al[15], head.al};
		mb   = head.is_byte ? {{9{sx & head.b[7]}}, head.b[7:0]}
			: {sx & head.b[15], head.b};
		prod = 34'($signed(ma) * $signed(mb));
		p    = prod[31:0];
		if (head.is_byte) begin
			mul_big = sx ? !(p[15:7] == 9'h000 || p[15:7] == 9'h1FF) : (p[15:8] != 8'h00);
		end else begin
			mul_big = sx ? !(p[31:15] == 17'h00000 || p[31:15] == 17'h1FFFF)
				: (p[31:16] != 16'h0000);
		end

		ex   = '0;
		fres = '0;
		unique case (head.op)
			OP_ADD: begin
				fres    = sum[15:0] & m;
				ex.cf   = head.is_byte ? sum[8] : sum[16];
				ex.of   = |(~(head.a ^ head.b) & (head.a ^ fres) & top);
				ex.dres = fres;
				ex.wd   = 1'b1;
				ex.fv   = 1'b1;
			end
			OP_SUB, OP_CMP: begin
				fres    = diff[15:0] & m;
				ex.cf   = diff[16];
				ex.of   = |((head.a ^ head.b) & (head.a ^ fres) & top);
				ex.dres = (head.op == OP_SUB) ? fres : 16'h0000;
				ex.wd   = head.op == OP_SUB;
				ex.fv   = 1'b1;
			end
			OP_AND, OP_OR, OP_XOR: begin
				fres    = (head.op == OP_AND) ? (head.a & head.b)
					: (head.op == OP_OR) ? (head.a | head.b) : (head.a ^ head.b);
				ex.dres = fres;
				ex.wd   = 1'b1;
				ex.fv   = 1'b1;
			end
			OP_NOT: begin
				ex.dres = ~head.a & m;
				ex.wd   = 1'b1;
			end
			OP_MUL, OP_IMUL: begin
				fres  = p[15:0] & m;
				ex.lo = p[15:0];
				ex.hi = head.is_byte ? 16'h0000 : p[31:16];
				ex.wl = 1'b1;
				ex.wh = ~head.is_byte;
				ex.cf = mul_big;
				ex.of = mul_big;
				ex.fv = 1'b1;
			end
			OP_DIV, OP_IDIV, OP_NOP: begin
				fres = '0;
			end
			default: begin
				fres = '0;
			end
		endcase
		if (ex.fv) begin
			ex.sf = |(fres & top);
			ex.zf = fres == 16'h0000;
		end

		ex_ctl.is_div    = (head.op == OP_DIV) || (head.op == OP_IDIV);
		ex_ctl.is_signed = head.op == OP_IDIV;
		ex_ctl.is_byte   = head.is_byte;
		if (!head.is_byte) begin
			dvd = {head.ah, head.al};
		end else if (ex_ctl.is_signed) begin
			dvd = {{16{head.al[15]}}, head.al};
		end else begin
			dvd = {16'h0000, head.al};
		end
		ex_ctl.neg_d = ex_ctl.is_signed & dvd[31];
		mag_d        = ex_ctl.neg_d ? (32'h0 - dvd) : dvd;
		ex_ctl.neg_v = ex_ctl.is_signed & (head.is_byte ? head.b[7] : head.b[15]);
		vs           = head.is_byte ? {{8{head.b[7]}}, head.b[7:0]} : head.b;
		mag_v        = ex_ctl.neg_v ? (16'h0 - vs) : head.b;
		ex_ctl.dvsr  = mag_v;
		ex_ctl.bad   = (head.b == 16'h0000) || (mag_d[31:16] >= mag_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= head_valid;
			for (int k = 0; k < DIV_STEPS; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			out_valid_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s[0] <= ex;
			ctl_s[0] <= ex_ctl;
			rem_s[0] <= mag_d[31:16];
			quo_s[0] <= mag_d[15:0];
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		logic [16:0] part;
		logic        ge;
		logic [16:0] sub;

		assign part = {rem_s[g], quo_s[g][15]};
		assign ge   = part >= {1'b0, ctl_s[g].dvsr};
		assign sub  = part - {1'b0, ctl_s[g].dvsr};

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[g+1] <= res_s[g];
				ctl_s[g+1] <= ctl_s[g];
				rem_s[g+1] <= ge ? sub[15:0] : part[15:0];
				quo_s[g+1] <= {quo_s[g][14:0], ge};
			end
		end
	end

	div_ctl_t    fc;
	logic [15:0] q;
	logic [15:0] r;
	logic        neg_q;
	logic [15:0] qs;
	logic [15:0] rs;
	logic        rng;
	alu_res_t    fin;

	always_comb begin
		fc    = ctl_s[DIV_STEPS];
		q     = quo_s[DIV_STEPS];
		r     = rem_s[DIV_STEPS];
		neg_q = fc.neg_d ^ fc.neg_v;
		qs    = neg_q ? (16'h0 - q) : q;
		rs    = fc.neg_d ? (16'h0 - r) : r;
		if (!fc.is_signed) begin
			rng = fc.is_byte & (q[15:8] != 8'h00);
		end else if (fc.is_byte) begin
			rng = neg_q ? (q > 16'd128) : (q > 16'd127);
		end else begin
			rng = neg_q ? (q > 16'h8000) : (q > 16'h7FFF);
		end
		fin = res_s[DIV_STEPS];
		if (fc.is_div) begin
			fin = '0;
			if (fc.bad || rng) begin
				fin.de = 1'b1;
			end else begin
				fin.lo = fc.is_byte ? {rs[7:0], qs[7:0]} : qs;
				fin.hi = fc.is_byte ? 16'h0000 : rs;
				fin.wl = 1'b1;
				fin.wh = ~fc.is_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= fin;
		end
	end

	assign out_valid      = out_valid_q;
	assign dest_result    = out_q.dres;
	assign write_dest     = out_q.wd;
	assign acc_low_out    = out_q.lo;
	assign acc_high_out   = out_q.hi;
	assign write_acc_low  = out_q.wl;
	assign write_acc_high = out_q.wh;
	assign carry_flag     = out_q.cf;
	assign overflow_flag  = out_q.of;
	assign sign_flag      = out_q.sf;
	assign zero_flag      = out_q.zf;
	assign flags_valid    = out_q.fv;
	assign divide_error   = out_q.de;

	`ASSERT_ALWAYS(a_err_quiet, !out_valid_q || !out_q.de ||
		(!out_q.wd && !out_q.wl && !out_q.wh && !out_q.fv),
		"Divide error result carries a write or flags.")
	`ASSERT_ALWAYS(a_high_needs_low, !out_valid_q || !out_q.wh || out_q.wl,
		"High register written without the accumulator.")

endmodule

>>> test/tb_x86_style_alu_8_16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_style_alu_8_16
// Drives byte and word requests for every operation through the ALU, with
// random idle bursts on both sides, and compares each result field by field
// with an in-bench model of the arithmetic, flags and divide errors.
// ----------------------------------------------------------------------------
module tb_x86_style_alu_8_16;
	import xalu_pkg::*;

	typedef struct {
		logic [15:0] dres;
		logic        wd;
		logic [15:0] lo;
		logic [15:0] hi;
		logic        wl;
		logic        wh;
		logic        cf;
		logic        of;
		logic        sf;
		logic        zf;
		logic        fv;
		logic        de;
	} alu_out_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  mode;
	logic        is_byte;
	logic [15:0] dest_value;
	logic [15:0] src_value;
	logic [15:0] acc_low_in;
	logic [15:0] acc_high_in;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] dest_result;
	logic        write_dest;
	logic [15:0] acc_low_out;
	logic [15:0] acc_high_out;
	logic        write_acc_low;
	logic        write_acc_high;
	logic        carry_flag;
	logic        overflow_flag;
	logic        sign_flag;
	logic        zero_flag;
	logic        flags_valid;
	logic        divide_error;

	alu_out_t    expected_results[$];
	int          errors = 0;
	int          cycles = 0;
	int          stall_left = 0;
	bit          idle_enable = 1;

	x86_style_alu_8_16 u_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("x86_style_alu_8_16: mismatch");
			$finish;
		end
	end

	function automatic int signed sext_w(logic [15:0] v, bit byte_op);
		if (byte_op)
			return int'($signed(v[7:0]));
		return int'($signed(v));
	endfunction

	function automatic alu_out_t alu_compute(logic [3:0] op, bit byte_op, logic [15:0] dv,
		logic [15:0] sv, logic [15:0] al, logic [15:0] ah);
		alu_out_t r;
		logic [15:0] msk, topb, a, b, res;
		logic [16:0] s;
		logic [31:0] p, d, q, rm;
		int signed sp;
		longint signed sd, sdv, sq, sr;
		r = '{default: 0};
		msk = byte_op ? 16'h00FF : 16'hFFFF;
		topb = byte_op ? 16'h0080 : 16'h8000;
		a = dv & msk;
		b = sv & msk;
		res = 16'h0000;
		case (op)
			OP_ADD: begin
				s = a + b;
				res = s[15:0] & msk;
				r.cf = s > msk;
				r.of = ((~(a ^ b)) & (a ^ res) & topb) != 0;
				r.dres = res; r.wd = 1; r.fv = 1;
			end
			OP_SUB, OP_CMP: begin
				res = (a - b) & msk;
				r.cf = a < b;
				r.of = ((a ^ b) & (a ^ res) & topb) != 0;
				if (op == OP_SUB) begin
					r.dres = res; r.wd = 1;
				end
				r.fv = 1;
			end
			OP_AND, OP_OR, OP_XOR: begin
				res = (op == OP_AND) ? (a & b) : (op == OP_OR) ? (a | b) : (a ^ b);
				r.dres = res; r.wd = 1; r.fv = 1;
			end
			OP_NOT: begin
				r.dres = (~a) & msk; r.wd = 1;
			end
			OP_MUL: begin
				if (byte_op) begin
					p = al[7:0] * b;
					r.lo = p[15:0]; r.wl = 1;
					r.cf = p[15:8] != 0;
					res = {8'h00, p[7:0]};
				end else begin
					p = al * b;
					r.lo = p[15:0]; r.hi = p[31:16]; r.wl = 1; r.wh = 1;
					r.cf = p[31:16] != 0;
					res = p[15:0];
				end
				r.of = r.cf; r.fv = 1;
			end
			OP_IMUL: begin
				sp = sext_w(al, byte_op) * sext_w(b, byte_op);
				p = sp;
				r.lo = p[15:0]; r.wl = 1;
				if (byte_op) begin
					r.cf = sp < -128 || sp > 127;
					res = {8'h00, p[7:0]};
				end else begin
					r.hi = p[31:16]; r.wh = 1;
					r.cf = sp < -32768 || sp > 32767;
					res = p[15:0];
				end
				r.of = r.cf; r.fv = 1;
			end
			OP_DIV: begin
				if (b == 0)
					r.de = 1;
				else begin
					d = byte_op ? {16'h0, al} : {ah, al};
					q = d / b;
					rm = d % b;
					if (q > msk)
						r.de = 1;
					else if (byte_op) begin
						r.lo = {rm[7:0], q[7:0]}; r.wl = 1;
					end else begin
						r.lo = q[15:0]; r.hi = rm[15:0]; r.wl = 1; r.wh = 1;
					end
				end
			end
			OP_IDIV: begin
				if (b == 0)
					r.de = 1;
				else begin
					sdv = sext_w(b, byte_op);
					sd = byte_op ? longint'($signed(al)) : longint'($signed({ah, al}));
					sq = sd / sdv;
					sr = sd % sdv;
					if (byte_op ? (sq < -128 || sq > 127) : (sq < -32768 || sq > 32767))
						r.de = 1;
					else if (byte_op) begin
						r.lo = {sr[7:0], sq[7:0]}; r.wl = 1;
					end else begin
						r.lo = sq[15:0]; r.hi = sr[15:0]; r.wl = 1; r.wh = 1;
					end
				end
			end
			default: ;
		endcase
		if (r.de) begin
			r = '{default: 0};
			r.de = 1;
		end
		if (r.fv) begin
			r.sf = (res & topb) != 0;
			r.zf = (res & msk) == 0;
		end else begin
			r.cf = 0; r.of = 0;
		end
		return r;
	endfunction

	task automatic send_request(logic [3:0] op, bit byte_op, logic [15:0] dv, logic [15:0] sv,
		logic [15:0] al, logic [15:0] ah);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		is_byte <= byte_op;
		dest_value <= dv;
		src_value <= sv;
		acc_low_in <= al;
		acc_high_in <= ah;
		expected_results.push_back(alu_compute(op, byte_op, dv, sv, al, ah));
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_random(int count, bit well_formed_div);
		logic [3:0] op;
		bit byte_op;
		logic [15:0] sv, al, ah;
		for (int i = 0; i < count; i++) begin
			op = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 9) < 8)
				op = 4'($urandom_range(0, 10));
			byte_op = 1'($urandom_range(0, 1));
			sv = 16'($urandom);
			al = 16'($urandom);
			ah = 16'($urandom);
			// Keep most divisions in range so that quotients are exercised.
			if (well_formed_div && (op == OP_DIV || op == OP_IDIV) && $urandom_range(0, 3) != 0) begin
				if (byte_op)
					al = {1'b0, $urandom_range(0, 7) == 0 ? 7'h0 : al[14:8], al[7:0]};
				else
					ah = $urandom_range(0, 1) ? {16{al[15]}} : 16'h0;
				if (sv[7:0] == 0)
					sv[0] = 1'b1;
				if (byte_op)
					sv[7] = 1'($urandom_range(0, 1));
			end
			send_request(op, byte_op, 16'($urandom), sv, al, ah);
		end
	endtask

	task automatic test_directed();
		send_request(OP_ADD, 0, 16'hFFFF, 16'h0001, 0, 0);
		send_request(OP_ADD, 1, 16'h007F, 16'h0001, 0, 0);
		send_request(OP_ADD, 0, 16'h8000, 16'h8000, 0, 0);
		send_request(OP_SUB, 1, 16'h0000, 16'h0001, 0, 0);
		send_request(OP_SUB, 0, 16'h8000, 16'h0001, 0, 0);
		send_request(OP_CMP, 0, 16'h1234, 16'h1234, 0, 0);
		send_request(OP_AND, 1, 16'hFFFF, 16'h0F80, 0, 0);
		send_request(OP_OR, 0, 16'h0000, 16'h0000, 0, 0);
		send_request(OP_XOR, 0, 16'hAAAA, 16'h5555, 0, 0);
		send_request(OP_NOT, 1, 16'hFF00, 0, 0, 0);
		send_request(OP_MUL, 1, 0, 16'h00FF, 16'h00FF, 0);
		send_request(OP_MUL, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(OP_IMUL, 1, 0, 16'h0080, 16'h0080, 0);
		send_request(OP_IMUL, 0, 0, 16'hFFFF, 16'h0002, 0);
		send_request(OP_DIV, 1, 0, 0, 16'h1234, 0);
		send_request(OP_DIV, 1, 0, 16'h0001, 16'h0100, 0);
		send_request(OP_DIV, 0, 0, 16'h0007, 16'hFFFF, 16'h0003);
		send_request(OP_DIV, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFE);
		send_request(OP_IDIV, 1, 0, 16'h00FF, 16'hFF80, 0);
		send_request(OP_IDIV, 1, 0, 16'h00FD, 16'hFFF9, 0);
		send_request(OP_IDIV, 0, 0, 16'hFFFF, 16'h8000, 16'hFFFF);
		send_request(OP_IDIV, 0, 0, 16'h0003, 16'h0007, 16'h0000);
		send_request(OP_IDIV, 0, 0, 0, 16'h0001, 0);
		send_request(4'd11, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(OP_NOP, 1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
	endtask

	task automatic test_random();
		send_random(300, 1);
	endtask

	task automatic test_back_to_back();
		idle_enable = 0;
		send_random(80, 1);
	endtask

	always @(posedge clk) begin
		if (!arst_n || !idle_enable) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 14);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (dest_result !== e.dres) begin
					$error("dest_result exp %h got %h", e.dres, dest_result); errors++;
				end
				if (write_dest !== e.wd) begin
					$error("write_dest exp %b got %b", e.wd, write_dest); errors++;
				end
				if (acc_low_out !== e.lo) begin
					$error("acc_low_out exp %h got %h", e.lo, acc_low_out); errors++;
				end
				if (acc_high_out !== e.hi) begin
					$error("acc_high_out exp %h got %h", e.hi, acc_high_out); errors++;
				end
				if (write_acc_low !== e.wl) begin
					$error("write_acc_low exp %b got %b", e.wl, write_acc_low); errors++;
				end
				if (write_acc_high !== e.wh) begin
					$error("write_acc_high exp %b got %b", e.wh, write_acc_high); errors++;
				end
				if (carry_flag !== e.cf) begin
					$error("carry_flag exp %b got %b", e.cf, carry_flag); errors++;
				end
				if (overflow_flag !== e.of) begin
					$error("overflow_flag exp %b got %b", e.of, overflow_flag); errors++;
				end
				if (sign_flag !== e.sf) begin
					$error("sign_flag exp %b got %b", e.sf, sign_flag); errors++;
				end
				if (zero_flag !== e.zf) begin
					$error("zero_flag exp %b got %b", e.zf, zero_flag); errors++;
				end
				if (flags_valid !== e.fv) begin
					$error("flags_valid exp %b got %b", e.fv, flags_valid); errors++;
				end
				if (divide_error !== e.de) begin
					$error("divide_error exp %b got %b", e.de, divide_error); errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = OP_ADD;
		is_byte = 1'b0;
		dest_value = '0;
		src_value = '0;
		acc_low_in = '0;
		acc_high_in = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_back_to_back();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("x86_style_alu_8_16: match");
		else
			$display("x86_style_alu_8_16: mismatch");
		$finish;
	end
endmodule

>>> x86_style_alu_8_16.f
+incdir+rtl
rtl/xalu_pkg.sv
rtl/xalu_front.sv
rtl/xalu_queue.sv
rtl/xalu_back.sv
rtl/x86_style_alu_8_16.sv
test/tb_x86_style_alu_8_16.sv
